// ----- hdl/mbd_pkg.sv -----
// Shared types and constants for the mipmap box downsampler.
`default_nettype none
package mbd_pkg;
  localparam int MaxSizeLog2 = 12;
  localparam int LineDepth = 1 << MaxSizeLog2;
  localparam int LineAw = MaxSizeLog2;
  localparam int LvlW = 4;
  localparam int PosW = 12;

  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgEnable = 2'd2;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [10:0] texel_x;
    logic [10:0] texel_y;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        last_of_run;
    logic        image_done;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic start_level;
    logic commit;
    logic next_level;
    logic restart;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
    logic stop;
    logic emit_last;
    logic no_levels;
  } status_t;
endpackage
`default_nettype wire

// ----- hdl/mbd_datapath.sv -----
// Level walk datapath: positions, held texels, pair-sum line store, averaging.
`default_nettype none
module mbd_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mbd_pkg::cmd_t       cmd,
  input  wire mbd_pkg::in_item_t   in_data,
  input  wire logic [3:0]          wl_cfg,
  input  wire logic [3:0]          hl_cfg,
  output mbd_pkg::status_t         sts,
  output mbd_pkg::out_item_t       res
);
  localparam int Levels = mbd_pkg::MaxSizeLog2;
  localparam int LineAw = mbd_pkg::LineAw;
  localparam int PosW = mbd_pkg::PosW;

  logic [3:0] wl, hl, levels;
  assign wl = (wl_cfg > 4'(Levels)) ? 4'(Levels) : wl_cfg;
  assign hl = (hl_cfg > 4'(Levels)) ? 4'(Levels) : hl_cfg;
  assign levels = (wl > hl) ? wl : hl;

  logic [PosW-1:0] col_r [Levels];
  logic [PosW-1:0] row_r [Levels];
  logic [31:0]     held_r [Levels];
  logic [35:0]     line_mem [mbd_pkg::LineDepth];
  logic [35:0]     line_rd_r;

  logic [3:0]  k_r, k_nxt;
  logic [31:0] cur_r, cur_nxt;
  logic [3:0]  kk;
  logic [PosW-1:0] x, y;
  logic [3:0]  pwl, phl;
  logic [PosW:0] pw, ph;
  logic both, pos_odd, emits, quad;
  logic [LineAw:0] base;
  logic [LineAw-1:0] idx;
  logic [8:0] sum2 [4];
  logic [9:0] sum4 [4];
  logic [31:0] avg;
  logic [31:0] held_k;
  logic [3:0]  kn, pwl_n, phl_n;
  logic [PosW-1:0] xn, yn;
  logic both_n, next_emits;

  assign kk = k_r;
  assign x = col_r[kk];
  assign y = row_r[kk];
  assign held_k = held_r[kk];
  assign pwl = (wl > kk) ? wl - kk : 4'd0;
  assign phl = (hl > kk) ? hl - kk : 4'd0;
  assign pw = (PosW+1)'(1) << pwl;
  assign ph = (PosW+1)'(1) << phl;
  assign both = (pwl != 4'd0) && (phl != 4'd0);
  assign pos_odd = both ? x[0] : ((pwl != 4'd0) ? x[0] : y[0]);
  assign quad = both && y[0];
  assign emits = pos_odd && (!both || y[0]);
  assign base = ((LineAw+1)'(1) << wl) - (((LineAw+1)'(1) << wl) >> kk);
  assign idx = base[LineAw-1:0] + LineAw'(x[PosW-1:1]);

  // look ahead one level to mark the final transfer of a pixel
  assign kn = (kk == 4'(Levels-1)) ? kk : kk + 4'd1;
  assign xn = col_r[kn];
  assign yn = row_r[kn];
  assign pwl_n = (wl > kn) ? wl - kn : 4'd0;
  assign phl_n = (hl > kn) ? hl - kn : 4'd0;
  assign both_n = (pwl_n != 4'd0) && (phl_n != 4'd0);
  assign next_emits = both_n ? (xn[0] && yn[0]) : ((pwl_n != 4'd0) ? xn[0] : yn[0]);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum2[i] = {1'b0, cur_r[8*i +: 8]} + {1'b0, held_k[8*i +: 8]};
      sum4[i] = {1'b0, sum2[i]} + {1'b0, line_rd_r[9*i +: 9]};
      avg[8*i +: 8] = quad ? sum4[i][9:2] : sum2[i][8:1];
    end
  end

  always_comb begin
    k_nxt = k_r;
    cur_nxt = cur_r;
    if (cmd.load) begin
      k_nxt = 4'd0;
      cur_nxt = {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};
    end else if (cmd.next_level) begin
      k_nxt = k_r + 4'd1;
      cur_nxt = avg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 4'd0;
      for (int i = 0; i < Levels; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
      end
    end else begin
      k_r <= k_nxt;
      if (cmd.restart) begin
        for (int i = 0; i < Levels; i++) begin
          col_r[i] <= '0;
          row_r[i] <= '0;
        end
      end else if (cmd.commit) begin
        if ({1'b0, x} + 13'd1 >= pw) begin
          col_r[kk] <= '0;
          row_r[kk] <= ({1'b0, y} + 13'd1 >= ph) ? '0 : y + PosW'(1);
        end else begin
          col_r[kk] <= x + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (cmd.start_level) begin
      line_rd_r <= line_mem[idx];
    end
    if (cmd.commit) begin
      if (!pos_odd) begin
        held_r[kk] <= cur_r;
      end else if (both && !y[0]) begin
        line_mem[idx] <= {sum2[3], sum2[2], sum2[1], sum2[0]};
      end
    end
  end

  assign sts.done = emits;
  assign sts.stop = !emits || (kk + 4'd1 == levels);
  assign sts.emit_last = !emits || (kk + 4'd1 == levels) || !next_emits;
  assign sts.no_levels = (levels == 4'd0);

  always_comb begin
    res.level = kk + 4'd1;
    res.texel_x = (pwl != 4'd0) ? x[11:1] : 11'd0;
    res.texel_y = (phl != 4'd0) ? y[11:1] : 11'd0;
    res.red_out = avg[7:0];
    res.green_out = avg[15:8];
    res.blue_out = avg[23:16];
    res.alpha_out = avg[31:24];
    res.last_of_run = 1'b0;
    res.image_done = (kk + 4'd1 == levels);
  end
endmodule
`default_nettype wire

// ----- hdl/mbd_ctrl.sv -----
// Sequencer that walks one input pixel down the levels.
`default_nettype none
module mbd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mip_en,
  input  wire logic               cfg_we,
  input  wire mbd_pkg::status_t   sts,
  input  wire mbd_pkg::out_item_t res,
  output mbd_pkg::cmd_t           cmd,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mbd_pkg::out_item_t      out_data
);
  mbd_pkg::state_t st_r, st_nxt;
  logic ov_r, ov_nxt;
  mbd_pkg::out_item_t od_r, od_nxt;
  logic slot_free;

  assign slot_free = !ov_r || !out_stall;
  assign in_stall = (st_r != mbd_pkg::ST_IDLE);

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    ov_nxt = ov_r && out_stall;
    od_nxt = od_r;
    cmd.restart = cfg_we;
    case (st_r)
      mbd_pkg::ST_IDLE: begin
        if (in_valid && mip_en && !sts.no_levels) begin
          cmd.load = 1'b1;
          st_nxt = mbd_pkg::ST_READ;
        end
      end
      mbd_pkg::ST_READ: begin
        cmd.start_level = 1'b1;
        st_nxt = mbd_pkg::ST_CALC;
      end
      mbd_pkg::ST_CALC: begin
        if (!sts.done) begin
          cmd.commit = 1'b1;
          st_nxt = mbd_pkg::ST_IDLE;
        end else if (slot_free) begin
          cmd.commit = 1'b1;
          ov_nxt = 1'b1;
          od_nxt = res;
          od_nxt.last_of_run = sts.emit_last;
          if (sts.stop) begin
            st_nxt = mbd_pkg::ST_IDLE;
          end else begin
            cmd.next_level = 1'b1;
            st_nxt = mbd_pkg::ST_READ;
          end
        end
      end
      default: st_nxt = mbd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mbd_pkg::ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data = od_r;
endmodule
`default_nettype wire

// ----- hdl/mipmap_box_downsampler_unit.sv -----
// Top level of the mipmap box downsampler: registers, controller and datapath.
// Each accepted pixel walks the mip levels through one shared averaging unit;
// after the accept, each level visited takes a line-store read, then an
// update and emit. A stalled result holds the walk until the output slot
// frees. With mipmaps disabled or a 1x1 base a pixel is accepted from idle
// and produces no texel.
// Writing any register restarts the image at level position zero.
`default_nettype none
module mipmap_box_downsampler_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mbd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mbd_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [3:0]         cfg_data
);
  logic [3:0] wl_r, hl_r;
  logic en_r, cfg_we;
  mbd_pkg::cmd_t cmd;
  mbd_pkg::status_t sts;
  mbd_pkg::out_item_t res;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && (cfg_index == mbd_pkg::CfgWidth ||
                  cfg_index == mbd_pkg::CfgHeight || cfg_index == mbd_pkg::CfgEnable);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= 4'd8;
      hl_r <= 4'd8;
      en_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        mbd_pkg::CfgWidth:  wl_r <= cfg_data;
        mbd_pkg::CfgHeight: hl_r <= cfg_data;
        mbd_pkg::CfgEnable: en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mbd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .mip_en(en_r), .cfg_we(cfg_we), .sts(sts), .res(res), .cmd(cmd),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  mbd_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(in_data),
    .wl_cfg(wl_r), .hl_cfg(hl_r), .sts(sts), .res(res)
  );
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the mipmap box downsampler: table-driven and random pixels.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbd_pkg::*;

  localparam int TimeoutCycles = 400000;
  localparam int DrainCycles = 40;
  localparam int HoldCycles = 300;

  typedef struct {
    in_item_t  px;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CfgWidth;
  logic [3:0] cfg_data = '0;

  mipmap_box_downsampler_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  int unsigned mdl_wl = 8, mdl_hl = 8, mdl_en = 1;
  logic [8:0] line_sum [LineDepth][4];
  logic [7:0] held_px [MaxSizeLog2][4];
  int unsigned lvl_col [MaxSizeLog2+1];
  int unsigned lvl_row [MaxSizeLog2+1];

  out_item_t expected_texels[$];
  out_item_t new_texels[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic void restart_image();
    for (int i = 0; i <= MaxSizeLog2; i++) begin
      lvl_col[i] = 0;
      lvl_row[i] = 0;
    end
  endfunction

  function automatic void write_model_reg(logic [1:0] idx, logic [3:0] val);
    case (idx)
      CfgWidth: mdl_wl = 32'(val);
      CfgHeight: mdl_hl = 32'(val);
      CfgEnable: mdl_en = 32'(val[0]);
      default: return;
    endcase
    restart_image();
  endfunction

  function automatic void predict_texels(in_item_t px);
    int unsigned wl, hl, levels, pwl, phl, pw, ph, x, y, idx, shift;
    logic [7:0] cur [4];
    logic [9:0] sum [4];
    bit done;
    out_item_t r;
    new_texels.delete();
    if (!mdl_en) return;
    wl = (mdl_wl > MaxSizeLog2) ? MaxSizeLog2 : mdl_wl;
    hl = (mdl_hl > MaxSizeLog2) ? MaxSizeLog2 : mdl_hl;
    levels = (wl > hl) ? wl : hl;
    cur[0] = px.red_in; cur[1] = px.green_in; cur[2] = px.blue_in; cur[3] = px.alpha_in;
    for (int k = 0; k < levels; k++) begin
      pwl = (wl > k) ? wl - k : 0;
      phl = (hl > k) ? hl - k : 0;
      pw = 1 << pwl;
      ph = 1 << phl;
      x = lvl_col[k];
      y = lvl_row[k];
      shift = 1;
      done = 1'b0;
      if (x + 1 >= pw) begin
        lvl_col[k] = 0;
        lvl_row[k] = (y + 1 >= ph) ? 0 : y + 1;
      end else begin
        lvl_col[k] = x + 1;
      end
      if (pwl > 0 && phl > 0) begin
        if (!x[0]) begin
          held_px[k] = cur;
        end else begin
          idx = (((1 << wl) - ((1 << wl) >> k)) + (x >> 1)) & (LineDepth - 1);
          for (int i = 0; i < 4; i++) sum[i] = cur[i] + held_px[k][i];
          if (!y[0]) begin
            for (int i = 0; i < 4; i++) line_sum[idx][i] = sum[i][8:0];
          end else begin
            for (int i = 0; i < 4; i++) sum[i] = sum[i] + line_sum[idx][i];
            shift = 2;
            done = 1'b1;
          end
        end
      end else begin
        if (!(((pwl > 0) ? x : y) & 1)) begin
          held_px[k] = cur;
        end else begin
          for (int i = 0; i < 4; i++) sum[i] = cur[i] + held_px[k][i];
          done = 1'b1;
        end
      end
      if (!done) break;
      for (int i = 0; i < 4; i++) cur[i] = 8'(sum[i] >> shift);
      r.level = 4'(k + 1);
      r.texel_x = 11'((pwl > 0) ? (x >> 1) : 0);
      r.texel_y = 11'((phl > 0) ? (y >> 1) : 0);
      r.red_out = cur[0];
      r.green_out = cur[1];
      r.blue_out = cur[2];
      r.alpha_out = cur[3];
      r.last_of_run = 1'b0;
      r.image_done = (k + 1 == levels);
      new_texels.push_back(r);
    end
    if (new_texels.size() > 0) new_texels[new_texels.size()-1].last_of_run = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int exp);
    $display("mismatch %s: got %0h expected %0h", what, got, exp);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    cycles <= cycles + 1;
    if (cycles > TimeoutCycles) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_texels.size() == 0) begin
        report_mismatch("unexpected texel", int'(out_data.level), 0);
      end else begin
        e = expected_texels.pop_front();
        if (out_data.level != e.level)
          report_mismatch("level", int'(out_data.level), int'(e.level));
        if (out_data.texel_x != e.texel_x)
          report_mismatch("texel_x", int'(out_data.texel_x), int'(e.texel_x));
        if (out_data.texel_y != e.texel_y)
          report_mismatch("texel_y", int'(out_data.texel_y), int'(e.texel_y));
        if (out_data.red_out != e.red_out)
          report_mismatch("red", int'(out_data.red_out), int'(e.red_out));
        if (out_data.green_out != e.green_out)
          report_mismatch("green", int'(out_data.green_out), int'(e.green_out));
        if (out_data.blue_out != e.blue_out)
          report_mismatch("blue", int'(out_data.blue_out), int'(e.blue_out));
        if (out_data.alpha_out != e.alpha_out)
          report_mismatch("alpha", int'(out_data.alpha_out), int'(e.alpha_out));
        if (out_data.last_of_run != e.last_of_run)
          report_mismatch("last_of_run", int'(out_data.last_of_run), int'(e.last_of_run));
        if (out_data.image_done != e.image_done)
          report_mismatch("image_done", int'(out_data.image_done), int'(e.image_done));
      end
    end
  end

  // hold off the result side for a long stretch on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 34);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    write_model_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(in_item_t px, bit typed, out_item_t res);
    int gap;
    if (!quiet && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    predict_texels(px);
    if (typed) expected_texels.push_back(res);
    else foreach (new_texels[i]) expected_texels.push_back(new_texels[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_texels.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic out_item_t texel1(logic [7:0] v);
    out_item_t r;
    r = '{level: 4'd1, texel_x: '0, texel_y: '0, red_out: v, green_out: v, blue_out: v,
          alpha_out: v, last_of_run: 1'b1, image_done: 1'b1};
    return r;
  endfunction

  initial begin
    stim_row_t rows[$];
    int unsigned phases[$][4];
    in_item_t px;
    out_item_t none;
    none = '0;
    for (int i = 0; i < LineDepth; i++) for (int c = 0; c < 4; c++) line_sum[i][c] = '0;
    for (int i = 0; i < MaxSizeLog2; i++) for (int c = 0; c < 4; c++) held_px[i][c] = '0;
    restart_image();
    rows = '{
      '{32'hFFFF_FFFF, 0, none}, '{32'hFFFF_FFFF, 0, none},
      '{32'h0000_0000, 0, none}, '{32'h0000_0000, 1, texel1(8'h7F)},
      '{32'h0102_0304, 0, none}, '{32'h8040_2010, 0, none},
      '{32'h7F00_FF55, 0, none}, '{32'hAA33_CC0F, 0, none},
      '{32'h0000_0000, 0, none}, '{32'h0000_0000, 0, none},
      '{32'h0000_0000, 0, none}, '{32'h0000_0000, 1, texel1(8'h00)},
      '{32'hFFFF_FFFF, 0, none}, '{32'hFFFF_FFFF, 0, none},
      '{32'hFFFF_FFFF, 0, none}, '{32'hFFFF_FFFF, 1, texel1(8'hFF)}
    };
    phases = '{
      '{3, 2, 1, 64}, '{2, 3, 1, 64}, '{12, 0, 1, 40}, '{0, 12, 1, 40}, '{15, 0, 1, 30},
      '{0, 0, 1, 20}, '{2, 2, 0, 20}, '{1, 3, 1, 48}, '{4, 3, 1, 80}, '{1, 0, 1, 20}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset size is large: the first row completes nothing
    for (int i = 0; i < 20; i++) send_pixel($urandom, 0, none);
    settle();
    write_reg(CfgWidth, 4'd1);
    write_reg(CfgHeight, 4'd1);
    write_reg(CfgEnable, 4'd1);
    foreach (rows[i]) send_pixel(rows[i].px, rows[i].typed, rows[i].res);
    settle();
    foreach (phases[p]) begin
      write_reg(CfgWidth, 4'(phases[p][0]));
      write_reg(CfgHeight, 4'(phases[p][1]));
      write_reg(CfgEnable, 4'(phases[p][2] | ($urandom_range(1) << 1)));
      if (p == 3) write_reg(2'd3, 4'($urandom));
      quiet = (p == 1);
      for (int i = 0; i < phases[p][3]; i++) begin
        if (p == 8 && i == 10) hold_req <= 1'b1;
        if (p == 8 && i == 11) hold_req <= 1'b0;
        px = $urandom;
        send_pixel(px, 0, none);
      end
      settle();
    end
    quiet = 1'b0;
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
